// ----- hw/rtl/tsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented tree-PLRU package
// Request and response types, policy and operation codes, and the segment
// thresholds shared by the replacement logic.
// ----------------------------------------------------------------------------
package tsp_pkg;

  typedef enum logic [1:0] {
    MODE_PLRU   = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_RANDOM = 2'd2
  } policy_e;

  typedef enum logic {
    OP_TOUCH = 1'b0,
    OP_EVICT = 1'b1
  } op_e;

  // Evict segment choice: below the cold limit is cold, below the probation
  // limit is probation, anything else is hot.
  localparam logic [2:0] SEG_COLD_LIMIT = 3'd5;
  localparam logic [2:0] SEG_PROB_LIMIT = 3'd7;

  typedef struct packed {
    logic       op;
    logic [3:0] way;
    logic [2:0] segment_rand;
    logic [2:0] walk_rand;
  } req_t;

  typedef struct packed {
    logic       swap_valid;
    logic [3:0] swap_way;
    logic [3:0] victim_way;
  } rsp_t;

endpackage

// ----- hw/rtl/tsp_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented tree-PLRU: one segment tree
// Walks a heap-ordered PLRU bit tree to a leaf and computes the tree after a
// touch of a given leaf.
// ----------------------------------------------------------------------------
module tsp_tree #(
  parameter int unsigned Depth = 2
) (
  input  logic [(2**Depth)-2:0] tree_i,
  input  logic                  rand_walk_i,
  input  logic [2:0]            walk_rand_i,
  input  logic                  touch_en_i,
  input  logic [Depth-1:0]      touch_leaf_i,
  output logic [Depth-1:0]      leaf_o,
  output logic [(2**Depth)-2:0] tree_o
);

  // The leaf prefix gathered so far selects the node on the next level.
  always_comb begin
    logic [Depth-1:0] node;
    logic [Depth-1:0] pre;
    logic             dir;
    pre = '0;
    for (int l = 0; l < Depth; l++) begin
      node = Depth'((2**l) - 1) + pre;
      dir  = rand_walk_i ? walk_rand_i[l % 3] : tree_i[node];
      pre  = (pre << 1) | Depth'(dir);
    end
    leaf_o = pre;
  end

  // Every ancestor of the touched leaf is pointed away from it.
  always_comb begin
    tree_o = tree_i;
    if (touch_en_i) begin
      for (int l = 0; l < Depth; l++) begin
        for (int j = 0; j < (2**l); j++) begin
          if ((touch_leaf_i >> (Depth - l)) == Depth'(j)) begin
            tree_o[(2**l) - 1 + j] = ~touch_leaf_i[Depth-1-l];
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/three_segment_tree_plru.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented tree-PLRU replacement for one cache set
// Cold, probation and hot segments, each with its own PLRU tree; touches
// promote lines one segment up and evicts pick a victim by random segment.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, the input register and then the response
// register, with the walk and tree update in front of the response register;
// a request leaves the input register only when the response side can take it.
// Throughput: one request per cycle when the response side is not stalled;
// the tree bits written by one request are seen by the very next one.
// Reset: all tree bits clear, policy mode PLRU, both stages empty.
module three_segment_tree_plru #(
  parameter int unsigned WAYS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  tsp_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output tsp_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i
);

  import tsp_pkg::*;

  localparam int unsigned Quarter = WAYS / 4;
  localparam int unsigned QD      = $clog2(Quarter);
  localparam int unsigned HD      = QD + 1;
  localparam int unsigned WIdx    = HD + 1;

  logic [1:0] mode_q;

  logic [(2**QD)-2:0] cold_q, cold_d;
  logic [(2**QD)-2:0] prob_q, prob_d;
  logic [(2**HD)-2:0] hot_q, hot_d;

  logic s1_vld_q;
  req_t s1_req_q;
  logic rsp_vld_q;
  rsp_t rsp_q, rsp_d;

  logic out_take;
  logic s1_ready;
  logic fire;

  assign out_take    = !rsp_vld_q || rsp_ready_i;
  assign s1_ready    = !s1_vld_q || out_take;
  assign fire        = s1_vld_q && out_take;
  assign req_ready_o = s1_ready;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLRU;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Request decode.
  logic            is_touch;
  logic            in_range;
  logic [WIdx-1:0] way_x;
  logic            way_cold;
  logic            way_prob;
  logic            way_hot;
  logic            plru_upd;
  logic            rand_walk;

  assign is_touch  = (s1_req_q.op == OP_TOUCH);
  assign in_range  = (int'(s1_req_q.way) < WAYS);
  assign way_x     = WIdx'(s1_req_q.way);
  assign way_cold  = in_range && (way_x < WIdx'(Quarter));
  assign way_prob  = in_range && !way_cold && !way_x[WIdx-1];
  assign way_hot   = in_range && way_x[WIdx-1];
  assign plru_upd  = fire && is_touch && (mode_q == MODE_PLRU);
  assign rand_walk = (mode_q == MODE_RANDOM);

  logic [QD-1:0] cold_leaf;
  logic [QD-1:0] prob_leaf;
  logic [HD-1:0] hot_leaf;
  logic [HD-1:0] hot_touch_leaf;

  assign hot_touch_leaf = way_hot ? way_x[HD-1:0] : hot_leaf;

  // The cold tree is never touched, so it holds its reset value.
  tsp_tree #(.Depth(QD)) u_cold (
    .tree_i       (cold_q),
    .rand_walk_i  (rand_walk),
    .walk_rand_i  (s1_req_q.walk_rand),
    .touch_en_i   (1'b0),
    .touch_leaf_i (cold_leaf),
    .leaf_o       (cold_leaf),
    .tree_o       (cold_d)
  );

  tsp_tree #(.Depth(QD)) u_prob (
    .tree_i       (prob_q),
    .rand_walk_i  (rand_walk),
    .walk_rand_i  (s1_req_q.walk_rand),
    .touch_en_i   (plru_upd && way_cold),
    .touch_leaf_i (prob_leaf),
    .leaf_o       (prob_leaf),
    .tree_o       (prob_d)
  );

  tsp_tree #(.Depth(HD)) u_hot (
    .tree_i       (hot_q),
    .rand_walk_i  (rand_walk),
    .walk_rand_i  (s1_req_q.walk_rand),
    .touch_en_i   (plru_upd && (way_prob || way_hot)),
    .touch_leaf_i (hot_touch_leaf),
    .leaf_o       (hot_leaf),
    .tree_o       (hot_d)
  );

  always_comb begin
    rsp_d = '0;
    if (!is_touch) begin
      if (s1_req_q.segment_rand < SEG_COLD_LIMIT) begin
        rsp_d.victim_way = 4'(WIdx'({2'b00, cold_leaf}));
      end else if (s1_req_q.segment_rand < SEG_PROB_LIMIT) begin
        rsp_d.victim_way = 4'(WIdx'({2'b01, prob_leaf}));
      end else begin
        rsp_d.victim_way = 4'(WIdx'({1'b1, hot_leaf}));
      end
    end else if (way_cold) begin
      rsp_d.swap_valid = 1'b1;
      rsp_d.swap_way   = 4'(WIdx'({2'b01, prob_leaf}));
    end else if (way_prob) begin
      rsp_d.swap_valid = 1'b1;
      rsp_d.swap_way   = 4'(WIdx'({1'b1, hot_leaf}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cold_q <= '0;
      prob_q <= '0;
      hot_q  <= '0;
    end else if (fire) begin
      cold_q <= cold_d;
      prob_q <= prob_d;
      hot_q  <= hot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_q <= req_valid_i;
      end
      if (out_take) begin
        rsp_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && s1_ready) begin
      s1_req_q <= req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
